FILE: sv/urq_pkg.sv
// Shared types, constants and control/status structs for the grid radius query unit.
`timescale 1ns / 1ps
package urq_pkg;

  localparam int COORD_W          = 16;
  localparam int GRID_SIDE_DEF    = 4;
  localparam int BUCKET_SLOTS_DEF = 4;
  localparam int MAX_RESULTS      = 64;
  localparam logic [COORD_W-1:0] CELL_SIZE_RST = 16'd256;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_GATHER = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] radius;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] found_x;
    logic [COORD_W-1:0] found_y;
    logic               hit;
    logic               stored;
    logic               last;
  } out_t;

  typedef struct packed {
    logic accept;
    logic win_init;
    logic fill_rd;
    logic add_commit;
    logic fill_latch;
    logic slot_rd;
    logic slot_mul;
    logic take_hit;
    logic adv_slot;
    logic adv_cell;
    logic emit_final;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic is_gather;
    logic fill_zero;
    logic slot_more;
    logic cell_more;
    logic hit_take;
    logic pend_valid;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: sv/urq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module urq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/urq_div.sv
// Restoring divider, one quotient bit per cycle, shared divisor across lanes, with quotient mod grid.
`timescale 1ns / 1ps
module urq_div import urq_pkg::*; #(
  parameter int LANES = 3,
  parameter int GRID  = GRID_SIDE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [COORD_W-1:0]         divisor,
  input  logic [COORD_W-1:0]         dividend [LANES],
  output logic [COORD_W-1:0]         quot     [LANES],
  output logic [$clog2(GRID)-1:0]    qmod     [LANES],
  output logic                       done
);

  localparam int CW  = $clog2(GRID);
  localparam int CNW = $clog2(COORD_W);

  logic               busy;
  logic [CNW-1:0]     cnt;
  logic [COORD_W-1:0] dsr;
  logic [COORD_W-1:0] dvd      [LANES];
  logic [COORD_W-1:0] rem      [LANES];
  logic [COORD_W-1:0] rem_next [LANES];
  logic [CW-1:0]      qm_next  [LANES];
  logic               qbit     [LANES];

  always_comb begin
    logic [COORD_W:0] trial;
    logic [CW:0]      t;
    for (int i = 0; i < LANES; i++) begin
      trial   = {rem[i], dvd[i][COORD_W-1]};
      qbit[i] = (trial >= {1'b0, dsr});
      rem_next[i] = qbit[i] ? COORD_W'(trial - {1'b0, dsr}) : trial[COORD_W-1:0];
      t = {qmod[i], qbit[i]};
      qm_next[i] = (t >= (CW+1)'(GRID)) ? CW'(t - (CW+1)'(GRID)) : t[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNW'(COORD_W - 1);
      end else if (busy) begin
        cnt <= cnt - CNW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      for (int i = 0; i < LANES; i++) begin
        dvd[i]  <= dividend[i];
        rem[i]  <= '0;
        quot[i] <= '0;
        qmod[i] <= '0;
      end
    end else if (busy) begin
      for (int i = 0; i < LANES; i++) begin
        dvd[i]  <= {dvd[i][COORD_W-2:0], 1'b0};
        rem[i]  <= rem_next[i];
        quot[i] <= {quot[i][COORD_W-2:0], qbit[i]};
        qmod[i] <= qm_next[i];
      end
    end
  end

endmodule

FILE: sv/urq_ctrl.sv
// Sequencer for add and gather commands.
`timescale 1ns / 1ps
module urq_ctrl import urq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_sts_t    sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DIV      = 10'b0000000010,
    S_ADD_RD   = 10'b0000000100,
    S_ADD_WR   = 10'b0000001000,
    S_CELL_RD  = 10'b0000010000,
    S_CELL_CHK = 10'b0000100000,
    S_SLOT_RD  = 10'b0001000000,
    S_SLOT_MUL = 10'b0010000000,
    S_SLOT_CMP = 10'b0100000000,
    S_FINISH   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.is_gather) begin
            cmd.win_init = 1'b1;
            state_next   = S_CELL_RD;
          end else begin
            state_next = S_ADD_RD;
          end
        end
      end
      S_ADD_RD: begin
        cmd.fill_rd = 1'b1;
        state_next  = S_ADD_WR;
      end
      S_ADD_WR: begin
        if (sts.out_free) begin
          cmd.add_commit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_CELL_RD: begin
        cmd.fill_rd = 1'b1;
        state_next  = S_CELL_CHK;
      end
      S_CELL_CHK: begin
        cmd.fill_latch = 1'b1;
        if (!sts.fill_zero) begin
          state_next = S_SLOT_RD;
        end else if (sts.cell_more) begin
          cmd.adv_cell = 1'b1;
          state_next   = S_CELL_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SLOT_RD: begin
        cmd.slot_rd = 1'b1;
        state_next  = S_SLOT_MUL;
      end
      S_SLOT_MUL: begin
        cmd.slot_mul = 1'b1;
        state_next   = S_SLOT_CMP;
      end
      S_SLOT_CMP: begin
        if (!(sts.hit_take && sts.pend_valid && !sts.out_free)) begin
          cmd.take_hit = 1'b1;
          if (sts.slot_more) begin
            cmd.adv_slot = 1'b1;
            state_next   = S_SLOT_RD;
          end else if (sts.cell_more) begin
            cmd.adv_cell = 1'b1;
            state_next   = S_CELL_RD;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/urq_dp.sv
// Datapath: cell size register, divider, bucket stores, scan counters, distance test, output beat.
`timescale 1ns / 1ps
module urq_dp import urq_pkg::*; #(
  parameter int GRID_SIDE    = GRID_SIDE_DEF,
  parameter int BUCKET_SLOTS = BUCKET_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COORD_W-1:0] cfg_wdata,
  input  in_t                in_data,
  input  logic               out_ready,
  output logic               out_valid,
  output out_t               out_data,
  input  ctrl_cmd_t          cmd,
  output dp_sts_t            sts
);

  localparam int CW = $clog2(GRID_SIDE);
  localparam int NC = GRID_SIDE * GRID_SIDE;
  localparam int IW = $clog2(NC);
  localparam int SW = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int FW = $clog2(BUCKET_SLOTS + 1);
  localparam int NP = NC * BUCKET_SLOTS;
  localparam int PW = $clog2(NP);
  localparam int NW = $clog2(MAX_RESULTS + 1);

  logic [COORD_W-1:0] cell_size;
  logic [COORD_W-1:0] eff_cs;
  in_t                item;

  // divider lanes: x, y, radius
  logic [COORD_W-1:0] dvd  [3];
  logic [COORD_W-1:0] quot [3];
  logic [CW-1:0]      qmod [3];
  logic               div_done;

  logic [CW-1:0] start_u, cur_u, cur_v, ccnt, rcnt;
  logic [2*COORD_W-1:0] r2, sqx, sqy;
  logic [NW-1:0] n;
  logic          pend_valid;
  logic [COORD_W-1:0] pend_x, pend_y;
  logic [FW-1:0] fill_cur, fill_q, fill_val;
  logic [SW-1:0] slot;
  logic          fvq;
  logic [NC-1:0] fill_vld;
  logic [2*COORD_W-1:0] pt_q;
  logic          out_free, hit_le, hit_take, room;
  logic [IW-1:0] add_idx, cur_idx, fill_raddr;
  logic [PW-1:0] pt_raddr, pt_waddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= CELL_SIZE_RST;
    end else if (cfg_we) begin
      cell_size <= cfg_wdata;
    end
  end

  assign eff_cs = (cell_size == '0) ? COORD_W'(1) : cell_size;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= in_data;
    end
  end

  assign dvd[0] = in_data.pos_x;
  assign dvd[1] = in_data.pos_y;
  assign dvd[2] = in_data.radius;

  urq_div #(.LANES(3), .GRID(GRID_SIDE)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.accept),
    .divisor  (eff_cs),
    .dividend (dvd),
    .quot     (quot),
    .qmod     (qmod),
    .done     (div_done)
  );

  // scan window from the query cell
  logic [COORD_W+1:0] sp1;
  logic               full;
  logic [CW-1:0]      s_s, u0, v0, win_u, win_v;
  logic [CW:0]        span_w;

  always_comb begin
    sp1    = {2'b00, quot[2]} + (COORD_W+2)'(1);
    full   = ({sp1[COORD_W:0], 1'b0} >= (COORD_W+2)'(2 * GRID_SIDE) >> 1) ||
             ({sp1[COORD_W:0], 1'b0} >= (COORD_W+2)'(GRID_SIDE));
    s_s    = sp1[CW-1:0];
    u0     = qmod[0];
    v0     = qmod[1];
    span_w = full ? (CW+1)'(GRID_SIDE) : {s_s, 1'b1};
    win_u  = full ? '0 : ((u0 >= s_s) ? CW'(u0 - s_s)
                         : CW'((CW+1)'(u0) + (CW+1)'(GRID_SIDE) - (CW+1)'(s_s)));
    win_v  = full ? '0 : ((v0 >= s_s) ? CW'(v0 - s_s)
                         : CW'((CW+1)'(v0) + (CW+1)'(GRID_SIDE) - (CW+1)'(s_s)));
  end

  logic [CW:0] span_q;
  logic        col_more, row_more;

  assign col_more = ((CW+1)'(ccnt) + (CW+1)'(1)) < span_q;
  assign row_more = ((CW+1)'(rcnt) + (CW+1)'(1)) < span_q;

  function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] a);
    logic [CW:0] t;
    t = (CW+1)'(a) + (CW+1)'(1);
    return (t == (CW+1)'(GRID_SIDE)) ? '0 : t[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.win_init) begin
      span_q  <= span_w;
      start_u <= win_u;
      cur_u   <= win_u;
      cur_v   <= win_v;
      ccnt    <= '0;
      rcnt    <= '0;
      r2      <= item.radius * item.radius;
    end else if (cmd.adv_cell) begin
      if (col_more) begin
        ccnt  <= ccnt + CW'(1);
        cur_u <= wrap_inc(cur_u);
      end else begin
        ccnt  <= '0;
        cur_u <= start_u;
        rcnt  <= rcnt + CW'(1);
        cur_v <= wrap_inc(cur_v);
      end
    end
  end

  assign add_idx    = IW'(IW'(qmod[1]) * IW'(GRID_SIDE) + IW'(qmod[0]));
  assign cur_idx    = IW'(IW'(cur_v) * IW'(GRID_SIDE) + IW'(cur_u));
  assign fill_raddr = (item.cmd == CMD_GATHER) ? cur_idx : add_idx;
  assign fill_val   = fvq ? fill_q : '0;
  assign room       = fill_val < FW'(BUCKET_SLOTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_vld <= '0;
    end else if (cmd.add_commit && room) begin
      fill_vld[add_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_rd) begin
      fvq <= fill_vld[fill_raddr];
    end
  end

  urq_ram #(.WIDTH(FW), .DEPTH(NC)) u_fill_ram (
    .clk   (clk),
    .we    (cmd.add_commit && room),
    .waddr (add_idx),
    .wdata (fill_val + FW'(1)),
    .re    (cmd.fill_rd),
    .raddr (fill_raddr),
    .rdata (fill_q)
  );

  assign pt_waddr = PW'(PW'(add_idx) * PW'(BUCKET_SLOTS) + PW'(fill_val));
  assign pt_raddr = PW'(PW'(cur_idx) * PW'(BUCKET_SLOTS) + PW'(slot));

  urq_ram #(.WIDTH(2*COORD_W), .DEPTH(NP)) u_pt_ram (
    .clk   (clk),
    .we    (cmd.add_commit && room),
    .waddr (pt_waddr),
    .wdata ({item.pos_y, item.pos_x}),
    .re    (cmd.slot_rd),
    .raddr (pt_raddr),
    .rdata (pt_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.fill_latch) begin
      fill_cur <= fill_val;
      slot     <= '0;
    end else if (cmd.adv_slot) begin
      slot <= slot + SW'(1);
    end
  end

  // distance test
  logic [COORD_W-1:0] ox, oy, dx, dy;

  assign ox = pt_q[COORD_W-1:0];
  assign oy = pt_q[2*COORD_W-1:COORD_W];
  assign dx = (ox > item.pos_x) ? ox - item.pos_x : item.pos_x - ox;
  assign dy = (oy > item.pos_y) ? oy - item.pos_y : item.pos_y - oy;

  always_ff @(posedge clk) begin
    if (cmd.slot_mul) begin
      sqx <= dx * dx;
      sqy <= dy * dy;
    end
  end

  assign hit_le   = ({1'b0, sqx} + {1'b0, sqy}) <= {1'b0, r2};
  assign hit_take = hit_le && (n < NW'(MAX_RESULTS));

  // one hit held back so that the final beat can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      n          <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.win_init || cmd.emit_final) begin
      n          <= '0;
      pend_valid <= 1'b0;
    end else if (cmd.take_hit && hit_take) begin
      n          <= n + NW'(1);
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_hit && hit_take) begin
      pend_x <= ox;
      pend_y <= oy;
    end
  end

  logic load_out;
  out_t out_next;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    load_out = 1'b0;
    out_next = '0;
    if (cmd.add_commit) begin
      load_out        = 1'b1;
      out_next.stored = room;
      out_next.last   = 1'b1;
    end else if (cmd.take_hit && hit_take && pend_valid) begin
      load_out         = 1'b1;
      out_next.found_x = pend_x;
      out_next.found_y = pend_y;
      out_next.hit     = 1'b1;
    end else if (cmd.emit_final) begin
      load_out      = 1'b1;
      out_next.last = 1'b1;
      if (pend_valid) begin
        out_next.found_x = pend_x;
        out_next.found_y = pend_y;
        out_next.hit     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= out_next;
    end
  end

  always_comb begin
    sts            = '0;
    sts.div_done   = div_done;
    sts.is_gather  = (item.cmd == CMD_GATHER);
    sts.fill_zero  = (fill_val == '0);
    sts.slot_more  = (FW'(slot) + FW'(1)) < fill_cur;
    sts.cell_more  = col_more || row_more;
    sts.hit_take   = hit_take;
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
  end

  a_cap: assert property (@(posedge clk) disable iff (rst) n <= NW'(MAX_RESULTS))
    else $error("hit count beyond cap");
  a_pend: assert property (@(posedge clk) disable iff (rst) pend_valid |-> n != '0)
    else $error("held hit without count");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.hit) |-> !out_data.stored)
    else $error("gather beat flagged as stored");
  a_span: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.win_init) |-> (span_q != '0 && span_q <= (CW+1)'(GRID_SIDE)))
    else $error("scan span out of range");

endmodule

FILE: sv/uniform_grid_radius_query_unit.sv
// Top level of the uniform grid radius query unit: controller plus datapath.
// Sequence: an add divides, reads the fill count, then writes and registers its result
//   beat. A gather divides, then reads and checks each scanned cell and tests each stored
//   slot; its beats, and the add's beat, can be held by output stalls.
// Throughput: one item in flight; the next is accepted the cycle after the last beat registers.
// Reset (rst, synchronous, active high): cell_size returns to 256, fill counts read as zero.
`timescale 1ns / 1ps
module uniform_grid_radius_query_unit import urq_pkg::*; #(
  parameter int GRID_SIDE    = GRID_SIDE_DEF,
  parameter int BUCKET_SLOTS = BUCKET_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [COORD_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_t               out_data
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // Sequencer: accepts the item, steps the divide, the cell walk and the slot
  // tests, and stalls whenever a beat must go out while the output is full.
  urq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: cell size register, shared divider lanes (x, y, radius), bucket
  // fill and point memories, window counters, squared distance compare, and
  // the output register. One hit is held back so the final beat carries last.
  urq_dp #(
    .GRID_SIDE    (GRID_SIDE),
    .BUCKET_SLOTS (BUCKET_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: tb/sv/uniform_grid_radius_query_unit_tb.sv
// Testbench for the uniform grid radius query unit: directed and random adds and gathers.
`timescale 1ns / 1ps
module uniform_grid_radius_query_unit_tb import urq_pkg::*; ();

  localparam int SIDE      = GRID_SIDE_DEF;
  localparam int SLOTS     = BUCKET_SLOTS_DEF;
  localparam int NCELLS    = SIDE * SIDE;
  localparam int IDLE_LIM  = 20000;
  localparam int SETTLE    = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [COORD_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // Grid model: fill count and stored points per bucket, plus the cell size.
  int unsigned grid_fill [NCELLS];
  logic [COORD_W-1:0] grid_px [NCELLS][SLOTS];
  logic [COORD_W-1:0] grid_py [NCELLS][SLOTS];
  logic [COORD_W-1:0] cur_cell;

  out_t pending_beats [$];
  bit   failed = 1'b0;
  bit   calm = 1'b0;     // no idling on either side during this stretch
  int   quiet_cycles = 0;

  always #10 clk = ~clk;

  uniform_grid_radius_query_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Work out the result beats that one accepted command produces.
  task automatic predict_query(input in_t item);
    int unsigned cs, u, v, idx, s, n;
    int lo, hi;
    longint unsigned r2, dx, dy;
    out_t beat;
    cs = (cur_cell == 0) ? 1 : cur_cell;
    u = (item.pos_x / cs) % SIDE;
    v = (item.pos_y / cs) % SIDE;
    beat = '0;
    if (item.cmd == CMD_ADD) begin
      idx = v * SIDE + u;
      if (grid_fill[idx] < SLOTS) begin
        grid_px[idx][grid_fill[idx]] = item.pos_x;
        grid_py[idx][grid_fill[idx]] = item.pos_y;
        grid_fill[idx]++;
        beat.stored = 1'b1;
      end
      beat.last = 1'b1;
      pending_beats.push_back(beat);
      return;
    end
    s = 1 + item.radius / cs;
    r2 = longint'(item.radius) * item.radius;
    n = 0;
    if (2 * s >= SIDE) begin
      lo = 0; hi = SIDE - 1;
    end else begin
      lo = -int'(s); hi = int'(s);
    end
    for (int vv = lo; vv <= hi; vv++) begin
      for (int uu = lo; uu <= hi; uu++) begin
        int wu, wv;
        // Wrap around the torus; whole-grid scans use absolute cells.
        if (2 * s >= SIDE) begin
          wu = uu; wv = vv;
        end else begin
          wu = ((int'(u) + uu) % SIDE + SIDE) % SIDE;
          wv = ((int'(v) + vv) % SIDE + SIDE) % SIDE;
        end
        idx = wv * SIDE + wu;
        for (int c = 0; c < grid_fill[idx]; c++) begin
          dx = (grid_px[idx][c] > item.pos_x) ? grid_px[idx][c] - item.pos_x
                                              : item.pos_x - grid_px[idx][c];
          dy = (grid_py[idx][c] > item.pos_y) ? grid_py[idx][c] - item.pos_y
                                              : item.pos_y - grid_py[idx][c];
          if (dx * dx + dy * dy <= r2 && n < MAX_RESULTS) begin
            beat = '0;
            beat.found_x = grid_px[idx][c];
            beat.found_y = grid_py[idx][c];
            beat.hit = 1'b1;
            pending_beats.push_back(beat);
            n++;
          end
        end
      end
    end
    if (n == 0) begin
      beat = '0;
      beat.last = 1'b1;
      pending_beats.push_back(beat);
    end else begin
      pending_beats[$].last = 1'b1;
    end
  endtask

  // Send one command beat; predict at the accepting edge.
  task automatic send_cmd(input logic cmd, input logic [15:0] x, input logic [15:0] y,
                          input logic [15:0] r);
    in_t item;
    item.cmd = cmd; item.pos_x = x; item.pos_y = y; item.radius = r;
    // step off the edge that dropped valid for the previous beat
    @(posedge clk);
    while (!calm && $urandom_range(99) < 14) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_query(item);
    in_valid <= 1'b0;
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while (pending_beats.size() != 0 && guard < IDLE_LIM * 4) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the cell size while idle; refill the grid model from scratch is not possible,
  // so the stored points stay and only their future cells change.
  task automatic set_cell(input logic [15:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_cell  = val;
  endtask

  // Receiver: random stalls, compare each beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_beats.size() == 0) begin
          $error("unexpected result beat %p", out_data);
          failed = 1'b1;
        end else begin
          out_t exp_b;
          exp_b = pending_beats.pop_front();
          if (out_data.found_x !== exp_b.found_x) begin
            $error("found_x expected %0h actual %0h", exp_b.found_x, out_data.found_x);
            failed = 1'b1;
          end
          if (out_data.found_y !== exp_b.found_y) begin
            $error("found_y expected %0h actual %0h", exp_b.found_y, out_data.found_y);
            failed = 1'b1;
          end
          if (out_data.hit !== exp_b.hit) begin
            $error("hit expected %0b actual %0b", exp_b.hit, out_data.hit);
            failed = 1'b1;
          end
          if (out_data.stored !== exp_b.stored) begin
            $error("stored expected %0b actual %0b", exp_b.stored, out_data.stored);
            failed = 1'b1;
          end
          if (out_data.last !== exp_b.last) begin
            $error("last expected %0b actual %0b", exp_b.last, out_data.last);
            failed = 1'b1;
          end
        end
      end
      out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
    end
  end

  // Watchdog: count cycles with no accepted beat on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIM) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Grid corners, field extremes, full bucket drop, empty gather.
  task automatic test_directed;
    send_cmd(CMD_GATHER, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(CMD_ADD, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(CMD_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_ADD, 16'h0010, 16'h0020, 16'h0000);
    send_cmd(CMD_ADD, 16'h0040, 16'h0080, 16'h0000);
    send_cmd(CMD_ADD, 16'h00FF, 16'h00FF, 16'h0000);
    // Bucket zero now full: this one is dropped.
    send_cmd(CMD_ADD, 16'h0001, 16'h0001, 16'h0000);
    send_cmd(CMD_ADD, 16'h0400, 16'h0400, 16'h0000);
    send_cmd(CMD_GATHER, 16'h0000, 16'h0000, 16'h0000);
    send_cmd(CMD_GATHER, 16'h0050, 16'h0050, 16'h0040);
    send_cmd(CMD_GATHER, 16'hFFFF, 16'hFFFF, 16'h0000);
    send_cmd(CMD_GATHER, 16'h8000, 16'h8000, 16'hFFFF);
    send_cmd(CMD_GATHER, 16'h0100, 16'h0300, 16'h0010);
  endtask

  // Adds, mostly in the low 0x0FFF range so hits are common, interleaved with gathers of varied radius.
  task automatic test_random(input int count);
    logic [15:0] cx, cy;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3 && i < count / 2);
      if ($urandom_range(99) < 45) begin
        cx = 16'($urandom); cy = 16'($urandom);
        if ($urandom_range(3) == 0)
          send_cmd(CMD_ADD, 16'($urandom), 16'($urandom), 16'($urandom));
        else
          send_cmd(CMD_ADD, cx & 16'h0FFF, cy & 16'h0FFF, 16'($urandom));
      end else begin
        case ($urandom_range(3))
          0: send_cmd(CMD_GATHER, 16'($urandom), 16'($urandom), 16'($urandom));
          1: send_cmd(CMD_GATHER, 16'($urandom) & 16'h0FFF, 16'($urandom) & 16'h0FFF,
                      16'($urandom_range(16'h0400)));
          default: send_cmd(CMD_GATHER, 16'($urandom) & 16'h0FFF, 16'($urandom) & 16'h0FFF,
                            16'($urandom_range(16'h0100)));
        endcase
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_cell_sizes;
    set_cell(16'h0040);
    test_random(50);
    set_cell(16'h0001);
    test_random(25);
    set_cell(16'hFFFF);
    test_random(25);
    set_cell(16'h0000);
    test_random(25);
    set_cell(16'h0100);
    test_random(25);
  endtask

  initial begin
    cur_cell = CELL_SIZE_RST;
    foreach (grid_fill[i]) grid_fill[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(60);
    test_cell_sizes();
    drain();
    if (pending_beats.size() == 0 && !failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
